/* rtl/isort_pkg.sv */
// Package for the insertion sorter: value type, cell command struct and state codes.
// No dependencies; every other file depends on it.
package isort_pkg;

  typedef logic signed [31:0] value_t;

  typedef struct packed {
    logic   ins;
    logic   shift;
    value_t value;
  } cell_cmd_t;

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

endpackage

/* rtl/isort_if.sv */
// Handshake interfaces for the input and result channels of the insertion sorter.
// Depends on isort_pkg for the value type.
interface isort_in_if;
  logic                 valid;
  logic                 ready;
  isort_pkg::value_t    sample_value;
  logic                 set_end;

  modport source (output valid, output sample_value, output set_end, input ready);
  modport sink   (input valid, input sample_value, input set_end, output ready);
endinterface

interface isort_out_if;
  logic                 valid;
  logic                 ready;
  isort_pkg::value_t    sorted_value;
  logic                 run_end;
  logic                 dropped;

  modport source (output valid, output sorted_value, output run_end, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input run_end, input dropped,
                  output ready);
endinterface

/* rtl/isort_cell.sv */
// One cell of the sorting chain: holds a value and an occupied flag.
// Depends on isort_pkg; instantiated by insertion_sorter.
module isort_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  isort_pkg::cell_cmd_t cmd,
  input  isort_pkg::value_t    left_val,
  input  logic                 left_gt,
  input  logic                 left_occ,
  input  isort_pkg::value_t    right_val,
  input  logic                 right_occ,
  output isort_pkg::value_t    val,
  output logic                 occ,
  output logic                 gt
);
  import isort_pkg::*;

  value_t val_r;
  value_t val_nxt;
  logic   occ_r;
  logic   occ_nxt;
  logic   take;

  // A held value greater than the new one moves up; the first empty cell also takes part.
  assign gt   = occ_r && (val_r > cmd.value);
  assign take = gt || (!occ_r && left_occ);

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (cmd.ins && take) begin
      val_nxt = left_gt ? left_val : cmd.value;
      occ_nxt = 1'b1;
    end else if (cmd.shift) begin
      val_nxt = right_val;
      occ_nxt = right_occ;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign val = val_r;
  assign occ = occ_r;

endmodule

/* rtl/insertion_sorter.sv */
// Top level of the streaming insertion sorter: a chain of sorting cells and an output register.
// Depends on isort_pkg, isort_if and isort_cell.
//
//   channel   direction  payload                          accepted when
//   in_ch     sink       sample_value, set_end            valid && ready
//   out_ch    source     sorted_value, run_end, dropped   valid && ready
//
// While a set fills, the cell chain inserts one item per cycle until full; more are dropped.
// After the marked item, the set's held values drain one per cycle unless the result channel
// stalls, as the chain shifts down, and no input item is taken during that time.
// A stall on the result channel holds the chain; the output register lets the next
// set start filling while the last result of a set still waits.
// Reset is synchronous and active low and empties the chain at once.
module insertion_sorter #(
  parameter int SORT_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  isort_in_if.sink     in_ch,
  isort_out_if.source  out_ch
);
  import isort_pkg::*;

  value_t              cell_val [SORT_DEPTH];
  logic [SORT_DEPTH-1:0] cell_occ;
  logic [SORT_DEPTH-1:0] cell_gt;
  cell_cmd_t           cmd;

  logic   state_r;
  logic   state_nxt;
  logic   ovf_r;
  logic   ovf_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  value_t out_val_r;
  logic   out_end_r;
  logic   out_drop_r;

  logic in_fire;
  logic out_load;
  logic full;
  logic last_load;

  assign full      = cell_occ[SORT_DEPTH-1];
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_load  = (state_r == ST_DRAIN) && (!out_valid_r || out_ch.ready);
  assign last_load = out_load && !cell_occ[1];

  assign cmd.ins   = in_fire && !full;
  assign cmd.shift = out_load;
  assign cmd.value = in_ch.sample_value;

  for (genvar i = 0; i < SORT_DEPTH; i++) begin : g_cell
    value_t lv;
    logic   lg;
    logic   lo;
    value_t rv;
    logic   ro;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
      assign lo = 1'b1;
    end else begin : g_mid
      assign lv = cell_val[i-1];
      assign lg = cell_gt[i-1];
      assign lo = cell_occ[i-1];
    end
    if (i == SORT_DEPTH - 1) begin : g_last
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_inner
      assign rv = cell_val[i+1];
      assign ro = cell_occ[i+1];
    end
    isort_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_val  (lv),
      .left_gt   (lg),
      .left_occ  (lo),
      .right_val (rv),
      .right_occ (ro),
      .val       (cell_val[i]),
      .occ       (cell_occ[i]),
      .gt        (cell_gt[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_FILL: begin
        if (in_fire) begin
          ovf_nxt = ovf_r | full;
          if (in_ch.set_end) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (last_load) begin
            state_nxt = ST_FILL;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val_r  <= cell_val[0];
      out_end_r  <= !cell_occ[1];
      out_drop_r <= ovf_r;
    end
  end

  assign in_ch.ready         = (state_r == ST_FILL);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_val_r;
  assign out_ch.run_end      = out_end_r;
  assign out_ch.dropped      = out_drop_r;

  // The occupied cells always form an unbroken run from the bottom of the chain.
  a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_occ & (cell_occ + 1'b1)) == '0)
    else $error("occupied cells are not contiguous");

  // A set being drained always has a value waiting in the bottom cell.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> cell_occ[0])
    else $error("drain with an empty chain");

  // A marked item starts the drain on the next cycle.
  a_mark_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.set_end) |=> (state_r == ST_DRAIN))
    else $error("marked item did not start the drain");

  // The last result of a set leaves the chain empty.
  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    last_load |=> (cell_occ == '0))
    else $error("chain not empty after the last result");

endmodule
